// ----- hw/rtl/rsw_pkg.sv -----
// ----------------------------------------------------------------------------
// rsw_pkg
// Shared widths, codes and types of the rolling shutter row shift warp core.
// ----------------------------------------------------------------------------
package rsw_pkg;

  localparam int CFG_W      = 11;
  localparam int BCNT_W     = 5;
  localparam int CNT_W      = 10;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 10;
  localparam int PIX_W      = 8;
  localparam int SHIFT_W    = 11;
  localparam int BIDX_W     = 4;
  localparam int CMD_W      = 2;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;
  localparam int IN_DW      = 24;
  localparam int OUT_DW     = 32;
  localparam int FIFO_DEPTH = 8;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_BANDS  = 16;

  localparam logic [CFG_W-1:0]  RST_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0]  RST_HEIGHT = 11'd480;
  localparam logic [BCNT_W-1:0] RST_BANDS  = 5'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_DRAIN = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_BANDS  = 2'd2
  } reg_idx_t;

  // clamped frame geometry
  typedef struct packed {
    logic [CFG_W-1:0]  width;
    logic [CFG_W-1:0]  height;
    logic [BCNT_W-1:0] bands;
  } eff_cfg_t;

  // one transaction as it moves down the pipeline
  typedef struct packed {
    logic               emit;
    logic               load;
    logic               wr;
    logic               last;
    logic               nz;
    logic [CFG_W-1:0]   row;
    logic [CFG_W-1:0]   col;
    logic [CFG_W-1:0]   km1;
    logic [BIDX_W-1:0]  bidx;
    logic [SHIFT_W-1:0] shift;
    logic [PIX_W-1:0]   pixel;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pixel;
    logic             last;
  } res_t;

endpackage

// ----- hw/rtl/rsw_ram.sv -----
// ----------------------------------------------------------------------------
// rsw_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/rsw_cfg.sv -----
// ----------------------------------------------------------------------------
// rsw_cfg
// APB register file for frame geometry, with clamped effective values.
// ----------------------------------------------------------------------------
module rsw_cfg #(
  parameter int MAX_WIDTH  = rsw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rsw_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_BANDS  = rsw_pkg::DEF_MAX_BANDS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [rsw_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [rsw_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [rsw_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  output rsw_pkg::eff_cfg_t           eff
);

  logic [rsw_pkg::CFG_W-1:0]  width_r;
  logic [rsw_pkg::CFG_W-1:0]  height_r;
  logic [rsw_pkg::BCNT_W-1:0] bands_r;
  rsw_pkg::reg_idx_t          idx;
  logic                       wr_en;

  assign idx        = rsw_pkg::reg_idx_t'(cfg_paddr[rsw_pkg::CFG_AW-1:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rsw_pkg::RST_WIDTH;
      height_r <= rsw_pkg::RST_HEIGHT;
      bands_r  <= rsw_pkg::RST_BANDS;
    end else if (wr_en) begin
      case (idx)
        rsw_pkg::REG_WIDTH:  width_r  <= cfg_pwdata[rsw_pkg::CFG_W-1:0];
        rsw_pkg::REG_HEIGHT: height_r <= cfg_pwdata[rsw_pkg::CFG_W-1:0];
        rsw_pkg::REG_BANDS:  bands_r  <= cfg_pwdata[rsw_pkg::BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rsw_pkg::REG_WIDTH:  cfg_prdata = rsw_pkg::CFG_DW'(width_r);
      rsw_pkg::REG_HEIGHT: cfg_prdata = rsw_pkg::CFG_DW'(height_r);
      rsw_pkg::REG_BANDS:  cfg_prdata = rsw_pkg::CFG_DW'(bands_r);
      default:             cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (width_r == '0) begin
      eff.width = rsw_pkg::CFG_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff.width = rsw_pkg::CFG_W'(MAX_WIDTH);
    end else begin
      eff.width = width_r;
    end
    if (height_r < rsw_pkg::CFG_W'(2)) begin
      eff.height = rsw_pkg::CFG_W'(2);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      eff.height = rsw_pkg::CFG_W'(MAX_HEIGHT);
    end else begin
      eff.height = height_r;
    end
    if (bands_r == '0) begin
      eff.bands = rsw_pkg::BCNT_W'(1);
    end else if (32'(bands_r) > MAX_BANDS) begin
      eff.bands = rsw_pkg::BCNT_W'(MAX_BANDS);
    end else begin
      eff.bands = bands_r;
    end
  end

endmodule

// ----- hw/rtl/rsw_band.sv -----
// ----------------------------------------------------------------------------
// rsw_band
// Two-stage band locator: D*(k-1) against registered thresholds j*R.
// ----------------------------------------------------------------------------
module rsw_band #(
  parameter int MAX_BANDS = rsw_pkg::DEF_MAX_BANDS
) (
  input  logic                             clk,
  input  logic [rsw_pkg::CFG_W-1:0]        hm1,
  input  logic [rsw_pkg::BCNT_W-1:0]       bands,
  input  logic [rsw_pkg::CFG_W-1:0]        km1,
  input  logic                             nz,
  output logic [$clog2(MAX_BANDS+1)-1:0]   band
);

  localparam int BW = $clog2(MAX_BANDS + 1);
  localparam int TW = rsw_pkg::CFG_W + rsw_pkg::BCNT_W + BW;

  logic [TW-1:0]        thr_r [MAX_BANDS];
  logic [TW-1:0]        p_r;
  logic                 nz_r;
  logic [MAX_BANDS-1:0] hit;
  logic [BW-1:0]        band_nxt;
  logic [BW-1:0]        band_r;

  // band = number of j in 0..D-1 with j*R <= D*(k-1)
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_BANDS; j++) begin
      thr_r[j] <= TW'(j) * TW'(hm1);
    end
    p_r    <= TW'(bands) * TW'(km1);
    nz_r   <= nz;
    band_r <= band_nxt;
  end

  always_comb begin
    for (int j = 0; j < MAX_BANDS; j++) begin
      hit[j] = (thr_r[j] <= p_r);
    end
    band_nxt = nz_r ? BW'($countones(hit)) : '0;
  end

  assign band = band_r;

endmodule

// ----- hw/rtl/rsw_fifo.sv -----
// ----------------------------------------------------------------------------
// rsw_fifo
// Result queue decoupling the pipeline from the output handshake.
// ----------------------------------------------------------------------------
module rsw_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rsw_pkg::res_t push_data,
  input  logic          pop,
  output logic          out_valid,
  output rsw_pkg::res_t out_data
);

  localparam int PW = $clog2(rsw_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(rsw_pkg::FIFO_DEPTH + 1);

  rsw_pkg::res_t mem_r [rsw_pkg::FIFO_DEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rp_r];
  assign do_pop    = pop && out_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(do_pop);
    end
  end

endmodule

// ----- hw/rtl/rolling_shutter_row_shift_warp_core.sv -----
// ----------------------------------------------------------------------------
// rolling_shutter_row_shift_warp_core
// Rolling shutter correction by shifting each row by its band's pixel shift.
// ----------------------------------------------------------------------------
// One input transaction is taken per clock while in_tready is high. A pixel of
// row y emits the corrected pixel of row y-1 at the same column; a drain
// transaction emits one pixel of the final row. Results pass registers s1_r to
// s3_r and the result stage, then an eight-entry queue; in_tready drops only
// while that queue is committed full. The band of a row is found in a two-stage
// multiply and compare unit, and the two row banks sit in one RAM with one write
// and one registered read per cycle. No clearing pass is needed after reset.
module rolling_shutter_row_shift_warp_core #(
  parameter int MAX_WIDTH  = rsw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rsw_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_BANDS  = rsw_pkg::DEF_MAX_BANDS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [rsw_pkg::IN_DW-1:0]   in_tdata,  // band_index, shift_pixels, pixel_in
  input  logic [rsw_pkg::CMD_W-1:0]   in_tuser,  // cmd
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [rsw_pkg::OUT_DW-1:0]  out_tdata, // out_row, out_col, out_pixel
  output logic                        out_tlast, // frame_end
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [rsw_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [rsw_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [rsw_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int AW  = $clog2(2 * MAX_WIDTH);
  localparam int BW  = $clog2(MAX_BANDS + 1);
  localparam int IW  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int CRW = $clog2(rsw_pkg::FIFO_DEPTH + 1);
  localparam int DW  = rsw_pkg::CFG_W + 2;
  localparam int CW  = rsw_pkg::CFG_W;

  rsw_pkg::eff_cfg_t eff;
  rsw_pkg::cmd_t     cmd;
  rsw_pkg::item_t    item;
  rsw_pkg::item_t    s1_r, s2_r, s3_r;
  rsw_pkg::res_t     res;
  rsw_pkg::res_t     fifo_q;

  logic [rsw_pkg::CNT_W-1:0] irc_r, irc_nxt;
  logic [rsw_pkg::CNT_W-1:0] icc_r, icc_nxt;
  logic [rsw_pkg::CNT_W-1:0] dcc_r, dcc_nxt;
  logic                      pend_r, pend_nxt;
  logic [CRW-1:0]            cr_r;

  logic [CW-1:0] hm1, wm1, row_c, col_c, dc_c;
  logic [AW-1:0] wa_s0, wa1_r, wa2_r, wa3_r;
  logic          acc, acc_emit, pop;

  logic [BW-1:0]      band;
  logic [IW-1:0]      tbl_idx;
  logic [rsw_pkg::SHIFT_W-1:0] shift_tbl_r [MAX_BANDS];
  logic [rsw_pkg::SHIFT_W-1:0] sh;
  logic [DW-1:0]      sdiff;
  logic               inr;
  logic [AW-1:0]      ra;
  logic [rsw_pkg::PIX_W-1:0] ram_q;

  logic               s4_emit_r, s4_last_r, s4_inr_r;
  logic [CW-1:0]      s4_row_r, s4_col_r;

  rsw_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_BANDS (MAX_BANDS)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .eff        (eff)
  );

  assign cmd       = rsw_pkg::cmd_t'(in_tuser);
  assign in_tready = (32'(cr_r) < rsw_pkg::FIFO_DEPTH);
  assign acc       = in_tvalid && in_tready;
  assign hm1       = eff.height - 1'b1;
  assign wm1       = eff.width - 1'b1;
  assign row_c     = (CW'(irc_r) > hm1) ? hm1 : CW'(irc_r);
  assign col_c     = (CW'(icc_r) > wm1) ? wm1 : CW'(icc_r);
  assign dc_c      = (CW'(dcc_r) > wm1) ? wm1 : CW'(dcc_r);

  // front end: counters and item build
  always_comb begin
    item     = '0;
    wa_s0    = row_c[0] ? AW'(MAX_WIDTH) + AW'(col_c) : AW'(col_c);
    irc_nxt  = irc_r;
    icc_nxt  = icc_r;
    dcc_nxt  = dcc_r;
    pend_nxt = pend_r;
    case (cmd)
      rsw_pkg::CMD_LOAD: begin
        item.load  = 1'b1;
        item.bidx  = in_tdata[3:0];
        item.shift = in_tdata[14:4];
      end
      rsw_pkg::CMD_PIXEL: begin
        item.wr    = 1'b1;
        item.pixel = in_tdata[22:15];
        if (row_c != '0) begin
          item.emit = 1'b1;
          item.row  = row_c - 1'b1;
          item.col  = col_c;
        end
        if (col_c == wm1) begin
          icc_nxt = '0;
          if (row_c == hm1) begin
            irc_nxt  = '0;
            pend_nxt = 1'b1;
            dcc_nxt  = '0;
          end else begin
            irc_nxt = rsw_pkg::CNT_W'(row_c + 1'b1);
          end
        end else begin
          icc_nxt = rsw_pkg::CNT_W'(col_c + 1'b1);
        end
      end
      rsw_pkg::CMD_DRAIN: begin
        if (pend_r) begin
          item.emit = 1'b1;
          item.row  = hm1;
          item.col  = dc_c;
          item.last = (dc_c == wm1);
          if (dc_c == wm1) begin
            pend_nxt = 1'b0;
            dcc_nxt  = '0;
          end else begin
            dcc_nxt = rsw_pkg::CNT_W'(dc_c + 1'b1);
          end
        end
      end
      default: ;
    endcase
    item.nz  = (item.row < hm1);
    item.km1 = item.nz ? (hm1 - item.row - 1'b1) : '0;
  end

  assign acc_emit = acc && item.emit;
  assign pop      = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irc_r  <= '0;
      icc_r  <= '0;
      dcc_r  <= '0;
      pend_r <= 1'b0;
      cr_r   <= '0;
      s1_r   <= '0;
      s2_r   <= '0;
      s3_r   <= '0;
      s4_emit_r <= 1'b0;
      for (int j = 0; j < MAX_BANDS; j++) begin
        shift_tbl_r[j] <= '0;
      end
    end else begin
      if (acc) begin
        irc_r  <= irc_nxt;
        icc_r  <= icc_nxt;
        dcc_r  <= dcc_nxt;
        pend_r <= pend_nxt;
      end
      cr_r      <= cr_r + CRW'(acc_emit) - CRW'(pop);
      s1_r      <= acc ? item : '0;
      s2_r      <= s1_r;
      s3_r      <= s2_r;
      s4_emit_r <= s3_r.emit;
      if (s3_r.load && (32'(s3_r.bidx) < MAX_BANDS)) begin
        shift_tbl_r[IW'(s3_r.bidx)] <= s3_r.shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    wa1_r     <= wa_s0;
    wa2_r     <= wa1_r;
    wa3_r     <= wa2_r;
    s4_last_r <= s3_r.last;
    s4_inr_r  <= inr;
    s4_row_r  <= s3_r.row;
    s4_col_r  <= s3_r.col;
  end

  rsw_band #(
    .MAX_BANDS(MAX_BANDS)
  ) u_band (
    .clk  (clk),
    .hm1  (hm1),
    .bands(eff.bands),
    .km1  (s1_r.km1),
    .nz   (s1_r.nz),
    .band (band)
  );

  // source column and row bank read
  always_comb begin
    tbl_idx = IW'(band - 1'b1);
    sh      = shift_tbl_r[tbl_idx];
    sdiff   = DW'(s3_r.col) - {{2{sh[rsw_pkg::SHIFT_W-1]}}, sh};
    inr     = (band != '0) && !sdiff[DW-1] && (sdiff[DW-2:0] < (DW-1)'(eff.width));
    ra      = s3_r.row[0] ? AW'(MAX_WIDTH) + AW'(sdiff) : AW'(sdiff);
  end

  rsw_ram #(
    .WIDTH(rsw_pkg::PIX_W),
    .DEPTH(2 * MAX_WIDTH)
  ) u_line (
    .clk  (clk),
    .we   (s3_r.wr),
    .waddr(wa3_r),
    .wdata(s3_r.pixel),
    .raddr(ra),
    .rdata(ram_q)
  );

  always_comb begin
    res.row   = s4_row_r[rsw_pkg::ROW_W-1:0];
    res.col   = s4_col_r[rsw_pkg::COL_W-1:0];
    res.pixel = s4_inr_r ? ram_q : '0;
    res.last  = s4_last_r;
  end

  rsw_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (s4_emit_r),
    .push_data(res),
    .pop      (out_tready),
    .out_valid(out_tvalid),
    .out_data (fifo_q)
  );

  assign out_tdata = {4'b0000, fifo_q.pixel, fifo_q.col, fifo_q.row};
  assign out_tlast = fifo_q.last;

  a_emit_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc_emit |-> ##4 s4_emit_r)
    else $error("emitting transaction did not reach the result stage");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cr_r) <= rsw_pkg::FIFO_DEPTH)
    else $error("result credit overflow");

  a_valid_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (cr_r != '0))
    else $error("result shown without credit");

  a_last_emit: assert property (@(posedge clk) disable iff (!rst_n)
    s3_r.last |-> s3_r.emit)
    else $error("frame end on a non-emitting transaction");

endmodule
